/* hdl/dcve_pkg.sv */
`timescale 1ns / 1ps
// dcve_pkg: shared types, constants and step functions for the disc collision pipeline.
// No dependencies; imported by disc_collision_velocity_exchange and its testbench.
package dcve_pkg;

	// pipeline geometry
	localparam int QW       = 25;          // quotient bits (|move| < 2^24.5)
	localparam int DW       = 48;          // divisor width (d.d when discs touch)
	localparam int DIV_BASE = 5;           // stage index of the divider's first register
	localparam int NUM_STG  = 33;          // total register stages, output included

	localparam logic signed [26:0] SUM_MAX = 27'sd8388607;
	localparam logic signed [26:0] SUM_MIN = -27'sd8388608;
	localparam logic signed [23:0] VEL_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] VEL_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [23:0] avx;
		logic signed [23:0] avy;
		logic signed [23:0] bvx;
		logic signed [23:0] bvy;
	} vel_t;

	// one divider stage: both move components share the divisor
	typedef struct packed {
		logic [DW-1:0] dd;
		logic [DW-1:0] remx;
		logic [QW-1:0] nlox;      // numerator bits not yet shifted in
		logic [QW-1:0] qx;
		logic [DW-1:0] remy;
		logic [QW-1:0] nloy;
		logic [QW-1:0] qy;
		logic          negx;
		logic          negy;
		logic          go;        // touching and d nonzero
		logic          hit;
		vel_t          vel;
	} div_t;

	// one restoring step per component: shift in a numerator bit, trial subtract
	function automatic div_t div_step(input div_t cur);
		div_t         nxt;
		logic [DW:0]  shx;
		logic [DW:0]  shy;
		logic [DW:0]  dv;
		nxt = cur;
		dv  = {1'b0, cur.dd};
		shx = {cur.remx, cur.nlox[QW-1]};
		shy = {cur.remy, cur.nloy[QW-1]};
		if (shx >= dv) begin
			nxt.remx = DW'(shx - dv);
			nxt.qx   = {cur.qx[QW-2:0], 1'b1};
		end else begin
			nxt.remx = shx[DW-1:0];
			nxt.qx   = {cur.qx[QW-2:0], 1'b0};
		end
		if (shy >= dv) begin
			nxt.remy = DW'(shy - dv);
			nxt.qy   = {cur.qy[QW-2:0], 1'b1};
		end else begin
			nxt.remy = shy[DW-1:0];
			nxt.qy   = {cur.qy[QW-2:0], 1'b0};
		end
		nxt.nlox = {cur.nlox[QW-2:0], 1'b0};
		nxt.nloy = {cur.nloy[QW-2:0], 1'b0};
		return nxt;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
		logic signed [23:0] r;
		if (v > SUM_MAX) begin
			r = VEL_MAX;
		end else if (v < SUM_MIN) begin
			r = VEL_MIN;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

/* hdl/disc_collision_velocity_exchange.sv */
`timescale 1ns / 1ps
// disc_collision_velocity_exchange: equal-mass elastic disc collision, fully pipelined.
// Depends on dcve_pkg (types, divider step, saturation).

// Takes one disc pair per clock while in_ready is high and returns the contact flag and
// the velocities after an equal-mass elastic exchange (Q15.8, saturated to 24 bits).
// The pipeline has 33 register stages, most of them in the 25-stage restoring divider
// that produces one quotient bit per stage for move = d*(rel.d)/(d.d), truncated
// toward zero. Front stages: differences, squares and dot products, sums, magnitudes,
// split 24x49 products, numerator assembly. Back stages: sign/mask of the move, then
// subtract/add with saturation into the output register.
// Each stage has its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles are squeezed out and input keeps being taken while a result waits.
// No contact or coincident centres pass the input velocities through unchanged.
module disc_collision_velocity_exchange (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] a_x,
	input  logic signed [23:0] a_y,
	input  logic signed [23:0] a_vx,
	input  logic signed [23:0] a_vy,
	input  logic        [22:0] a_r,
	input  logic signed [23:0] b_x,
	input  logic signed [23:0] b_y,
	input  logic signed [23:0] b_vx,
	input  logic signed [23:0] b_vy,
	input  logic        [22:0] b_r,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [23:0] new_a_vx,
	output logic signed [23:0] new_a_vy,
	output logic signed [23:0] new_b_vx,
	output logic signed [23:0] new_b_vy
);
	import dcve_pkg::*;

	// ---------------------------------------------------------------------------------
	// Flow control: stage k loads when any stage from k to the output is empty, or the
	// output transaction completes this cycle.
	// ---------------------------------------------------------------------------------
	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] ld;

	for (genvar k = 0; k < NUM_STG; k++) begin : g_ld
		assign ld[k] = out_ready | ~(&vld_q[NUM_STG-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~ld) | ({vld_q[NUM_STG-2:0], in_valid} & ld);
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = vld_q[NUM_STG-1];

	// ---------------------------------------------------------------------------------
	// S1: center difference d = B - A, relative velocity rel = vA - vB, radius sum.
	// ---------------------------------------------------------------------------------
	logic signed [24:0] dx_s1, dy_s1, rx_s1, ry_s1;
	logic        [23:0] rs_s1;
	vel_t               vel_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			dx_s1  <= $signed({b_x[23], b_x}) - $signed({a_x[23], a_x});
			dy_s1  <= $signed({b_y[23], b_y}) - $signed({a_y[23], a_y});
			rx_s1  <= $signed({a_vx[23], a_vx}) - $signed({b_vx[23], b_vx});
			ry_s1  <= $signed({a_vy[23], a_vy}) - $signed({b_vy[23], b_vy});
			rs_s1  <= {1'b0, a_r} + {1'b0, b_r};
			vel_s1 <= '{avx: a_vx, avy: a_vy, bvx: b_vx, bvy: b_vy};
		end
	end

	// ---------------------------------------------------------------------------------
	// S2: five 25x25 products in parallel. Squares stay below 2^48, cross terms below
	// 2^48 in magnitude.
	// ---------------------------------------------------------------------------------
	logic signed [49:0] sqx_c, sqy_c, pxx_c, pyy_c;
	logic        [47:0] rr_c;
	logic        [47:0] dxx_s2, dyy_s2, rr_s2;
	logic signed [48:0] pxx_s2, pyy_s2;
	logic signed [24:0] dx_s2, dy_s2;
	vel_t               vel_s2;

	always_comb begin
		sqx_c = dx_s1 * dx_s1;
		sqy_c = dy_s1 * dy_s1;
		pxx_c = rx_s1 * dx_s1;
		pyy_c = ry_s1 * dy_s1;
		rr_c  = rs_s1 * rs_s1;
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dxx_s2 <= sqx_c[47:0];
			dyy_s2 <= sqy_c[47:0];
			pxx_s2 <= pxx_c[48:0];
			pyy_s2 <= pyy_c[48:0];
			rr_s2  <= rr_c;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			vel_s2 <= vel_s1;
		end
	end

	// ---------------------------------------------------------------------------------
	// S3: d.d and rel.d
	// ---------------------------------------------------------------------------------
	logic        [48:0] dd_s3;
	logic signed [49:0] p_s3;
	logic        [47:0] rr_s3;
	logic signed [24:0] dx_s3, dy_s3;
	vel_t               vel_s3;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			dd_s3  <= {1'b0, dxx_s2} + {1'b0, dyy_s2};
			p_s3   <= $signed({pxx_s2[48], pxx_s2}) + $signed({pyy_s2[48], pyy_s2});
			rr_s3  <= rr_s2;
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			vel_s3 <= vel_s2;
		end
	end

	// ---------------------------------------------------------------------------------
	// S4: contact test, sign/magnitude split for the unsigned divider
	// ---------------------------------------------------------------------------------
	logic signed [49:0] negp_c;
	logic signed [24:0] negdx_c, negdy_c;
	logic               hit_c;

	logic        [48:0] ap_s4;
	logic        [23:0] adx_s4, ady_s4;
	logic        [DW-1:0] dd_s4;
	logic               hit_s4, go_s4, negx_s4, negy_s4;
	vel_t               vel_s4;

	always_comb begin
		negp_c  = -p_s3;
		negdx_c = -dx_s3;
		negdy_c = -dy_s3;
		hit_c   = dd_s3 <= {1'b0, rr_s3};
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			ap_s4   <= p_s3[49] ? negp_c[48:0] : p_s3[48:0];
			adx_s4  <= dx_s3[24] ? negdx_c[23:0] : dx_s3[23:0];
			ady_s4  <= dy_s3[24] ? negdy_c[23:0] : dy_s3[23:0];
			negx_s4 <= dx_s3[24] ^ p_s3[49];
			negy_s4 <= dy_s3[24] ^ p_s3[49];
			dd_s4   <= dd_s3[DW-1:0];       // below 2^48 whenever the discs touch
			hit_s4  <= hit_c;
			go_s4   <= hit_c && (dd_s3 != '0);
			vel_s4  <= vel_s3;
		end
	end

	// ---------------------------------------------------------------------------------
	// S5: |d| * |rel.d| as two partial products (24x25 and 24x24)
	// ---------------------------------------------------------------------------------
	logic [48:0] mxl_s5, myl_s5;
	logic [47:0] mxh_s5, myh_s5;
	logic [DW-1:0] dd_s5;
	logic        hit_s5, go_s5, negx_s5, negy_s5;
	vel_t        vel_s5;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			mxl_s5  <= adx_s4 * ap_s4[24:0];
			mxh_s5  <= adx_s4 * ap_s4[48:25];
			myl_s5  <= ady_s4 * ap_s4[24:0];
			myh_s5  <= ady_s4 * ap_s4[48:25];
			dd_s5   <= dd_s4;
			hit_s5  <= hit_s4;
			go_s5   <= go_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			vel_s5  <= vel_s4;
		end
	end

	// ---------------------------------------------------------------------------------
	// S6..S31: numerator assembly, then 25 restoring steps. div_s[i] is stage 6+i.
	// On contact the quotient fits 25 bits, so the top 48 numerator bits already sit
	// below d.d and seed the remainder.
	// ---------------------------------------------------------------------------------
	logic [72:0] nx_c, ny_c;
	div_t        init_c;
	div_t        div_s [QW+1];

	always_comb begin
		nx_c = {mxh_s5, 25'b0} + {24'b0, mxl_s5};
		ny_c = {myh_s5, 25'b0} + {24'b0, myl_s5};
		init_c      = '0;
		init_c.dd   = dd_s5;
		init_c.remx = nx_c[72:QW];
		init_c.nlox = nx_c[QW-1:0];
		init_c.remy = ny_c[72:QW];
		init_c.nloy = ny_c[QW-1:0];
		init_c.negx = negx_s5;
		init_c.negy = negy_s5;
		init_c.go   = go_s5;
		init_c.hit  = hit_s5;
		init_c.vel  = vel_s5;
	end

	always_ff @(posedge clk) begin
		if (ld[DIV_BASE]) begin
			div_s[0] <= init_c;
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_div
		always_ff @(posedge clk) begin
			if (ld[DIV_BASE+i]) begin
				div_s[i] <= div_step(div_s[i-1]);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// S32: signed move; zero when apart or centres coincide
	// ---------------------------------------------------------------------------------
	logic [25:0]        magx_c, magy_c;
	logic signed [25:0] mx_s32, my_s32;
	logic               hit_s32;
	vel_t               vel_s32;

	always_comb begin
		magx_c = {1'b0, div_s[QW].qx};
		magy_c = {1'b0, div_s[QW].qy};
	end

	always_ff @(posedge clk) begin
		if (ld[NUM_STG-2]) begin
			if (div_s[QW].go) begin
				mx_s32 <= div_s[QW].negx ? -$signed(magx_c) : $signed(magx_c);
				my_s32 <= div_s[QW].negy ? -$signed(magy_c) : $signed(magy_c);
			end else begin
				mx_s32 <= '0;
				my_s32 <= '0;
			end
			hit_s32 <= div_s[QW].hit;
			vel_s32 <= div_s[QW].vel;
		end
	end

	// ---------------------------------------------------------------------------------
	// S33: A - move, B + move, saturated; output register
	// ---------------------------------------------------------------------------------
	logic signed [26:0] sax_c, say_c, sbx_c, sby_c;
	logic               hit_s33;
	logic signed [23:0] avx_s33, avy_s33, bvx_s33, bvy_s33;

	always_comb begin
		sax_c = $signed({{3{vel_s32.avx[23]}}, vel_s32.avx}) - $signed({mx_s32[25], mx_s32});
		say_c = $signed({{3{vel_s32.avy[23]}}, vel_s32.avy}) - $signed({my_s32[25], my_s32});
		sbx_c = $signed({{3{vel_s32.bvx[23]}}, vel_s32.bvx}) + $signed({mx_s32[25], mx_s32});
		sby_c = $signed({{3{vel_s32.bvy[23]}}, vel_s32.bvy}) + $signed({my_s32[25], my_s32});
	end

	always_ff @(posedge clk) begin
		if (ld[NUM_STG-1]) begin
			hit_s33 <= hit_s32;
			avx_s33 <= sat24(sax_c);
			avy_s33 <= sat24(say_c);
			bvx_s33 <= sat24(sbx_c);
			bvy_s33 <= sat24(sby_c);
		end
	end

	assign hit      = hit_s33;
	assign new_a_vx = avx_s33;
	assign new_a_vy = avy_s33;
	assign new_b_vx = bvx_s33;
	assign new_b_vy = bvy_s33;

	// ---------------------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------------------
	// an accepted transaction always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction missing from first stage");

	// on contact the seeded remainder is below d.d, i.e. the quotient fits 25 bits
	a_div_seed: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_BASE] && div_s[0].go |->
			(div_s[0].remx < div_s[0].dd) && (div_s[0].remy < div_s[0].dd))
		else $error("divider seed not below divisor");

	// and the final remainder stays below it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_BASE+QW] && div_s[QW].go |->
			(div_s[QW].remx < div_s[QW].dd) && (div_s[QW].remy < div_s[QW].dd))
		else $error("divider remainder not below divisor");

	// no move is ever applied to a pair that does not touch
	a_no_move_apart: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NUM_STG-2] && !hit_s32 |-> (mx_s32 == '0) && (my_s32 == '0))
		else $error("nonzero move without contact");

endmodule

/* tb/tb_disc_collision_velocity_exchange.sv */
`timescale 1ns / 1ps
// tb_disc_collision_velocity_exchange: self-checking bench for the disc collision pipeline.
// Depends on dcve_pkg and disc_collision_velocity_exchange; reads no files, takes no args.
module tb_disc_collision_velocity_exchange;
	import dcve_pkg::*;

	// Run length guard. It is set well above the longest correct run, even with
	// both sides throttled; reaching it ends the run with TB_ERROR.
	localparam int CYCLE_LIMIT = 200000;
	// Pipeline depth is 33 stages; settle time after the last result.
	localparam int SETTLE      = 40;
	localparam int RAND_ITEMS  = 188;   // per idling phase, four phases

	// One disc pair, as presented on the input channel.
	typedef struct packed {
		logic signed [23:0] a_x;
		logic signed [23:0] a_y;
		logic signed [23:0] a_vx;
		logic signed [23:0] a_vy;
		logic        [22:0] a_r;
		logic signed [23:0] b_x;
		logic signed [23:0] b_y;
		logic signed [23:0] b_vx;
		logic signed [23:0] b_vy;
		logic        [22:0] b_r;
	} disc_pair_t;

	// Contact flag and velocities after exchange, as seen on the output channel.
	typedef struct packed {
		logic               hit;
		logic signed [23:0] new_a_vx;
		logic signed [23:0] new_a_vy;
		logic signed [23:0] new_b_vx;
		logic signed [23:0] new_b_vy;
	} collision_t;

	// Directed stimulus row: 'typed' rows carry a hand-derived answer,
	// the rest are checked against the predictor.
	typedef struct packed {
		disc_pair_t pair;
		bit         typed;
		collision_t want;
	} dir_row_t;

	localparam collision_t NO_RES = '0;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [23:0] a_x = '0;
	logic signed [23:0] a_y = '0;
	logic signed [23:0] a_vx = '0;
	logic signed [23:0] a_vy = '0;
	logic        [22:0] a_r = '0;
	logic signed [23:0] b_x = '0;
	logic signed [23:0] b_y = '0;
	logic signed [23:0] b_vx = '0;
	logic signed [23:0] b_vy = '0;
	logic        [22:0] b_r = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               hit;
	logic signed [23:0] new_a_vx;
	logic signed [23:0] new_a_vy;
	logic signed [23:0] new_b_vx;
	logic signed [23:0] new_b_vy;

	collision_t due_results[$];   // expected outcomes, oldest first
	dir_row_t   dir_rows[$];
	int         mismatches = 0;
	int         cycles = 0;
	int         idle_pct = 0;       // sender: chance in 100 of an idle cycle
	int         stall_pct = 0;      // receiver: chance in 100 of a stall cycle

	disc_collision_velocity_exchange dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_vx     (a_vx),
		.a_vy     (a_vy),
		.a_r      (a_r),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_vx     (b_vx),
		.b_vy     (b_vy),
		.b_r      (b_r),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit),
		.new_a_vx (new_a_vx),
		.new_a_vy (new_a_vy),
		.new_b_vx (new_b_vx),
		.new_b_vy (new_b_vy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic signed [23:0] clamp_vel(input longint v);
		if (v > longint'(VEL_MAX)) begin
			return VEL_MAX;
		end else if (v < longint'(VEL_MIN)) begin
			return VEL_MIN;
		end
		return 24'(v);
	endfunction

	// trunc(d * dot / dd), exact: the product needs up to 73 bits.
	function automatic longint share_of(input longint d, input longint dot,
			input longint unsigned dd);
		logic [127:0] mag;
		mag = 128'(d < 0 ? -d : d) * 128'(dot < 0 ? -dot : dot);
		mag = mag / {64'd0, dd};
		return ((d < 0) != (dot < 0)) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	// Equal-mass elastic exchange: the normal component of the relative
	// velocity moves from A to B. Coincident centres give no move.
	function automatic collision_t predict_exchange(input disc_pair_t p);
		collision_t         r;
		longint             dx, dy, rx, ry, rs, dot, mx, my;
		longint unsigned    dd, rr;
		dx = longint'(p.b_x) - longint'(p.a_x);
		dy = longint'(p.b_y) - longint'(p.a_y);
		rx = longint'(p.a_vx) - longint'(p.b_vx);
		ry = longint'(p.a_vy) - longint'(p.b_vy);
		rs = longint'(p.a_r) + longint'(p.b_r);
		dd = dx * dx + dy * dy;
		rr = rs * rs;
		r.hit = (dd <= rr);
		mx = 0;
		my = 0;
		if (r.hit && dd != 0) begin
			dot = rx * dx + ry * dy;
			mx = share_of(dx, dot, dd);
			my = share_of(dy, dot, dd);
		end
		r.new_a_vx = clamp_vel(longint'(p.a_vx) - mx);
		r.new_a_vy = clamp_vel(longint'(p.a_vy) - my);
		r.new_b_vx = clamp_vel(longint'(p.b_vx) + mx);
		r.new_b_vy = clamp_vel(longint'(p.b_vy) + my);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic disc_pair_t mk_pair(input int ax, input int ay, input int avx,
			input int avy, input int ar, input int bx, input int by, input int bvx,
			input int bvy, input int br);
		disc_pair_t p;
		p.a_x  = 24'(ax);
		p.a_y  = 24'(ay);
		p.a_vx = 24'(avx);
		p.a_vy = 24'(avy);
		p.a_r  = 23'(ar);
		p.b_x  = 24'(bx);
		p.b_y  = 24'(by);
		p.b_vx = 24'(bvx);
		p.b_vy = 24'(bvy);
		p.b_r  = 23'(br);
		return p;
	endfunction

	function automatic collision_t mk_res(input bit h, input int avx, input int avy,
			input int bvx, input int bvy);
		collision_t r;
		r.hit      = h;
		r.new_a_vx = 24'(avx);
		r.new_a_vy = 24'(avy);
		r.new_b_vx = 24'(bvx);
		r.new_b_vy = 24'(bvy);
		return r;
	endfunction

	// Velocity: half the time full-range, otherwise on the scale of the geometry.
	function automatic logic signed [23:0] rand_vel(input int span);
		if ($urandom_range(1, 0) == 1) begin
			return 24'($urandom);
		end
		return 24'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Random pair. Mostly close pairs (so contact and the divider path are
	// exercised across magnitudes), then fully random words, then coincident
	// centres and exact axis contact.
	function automatic disc_pair_t rand_pair();
		disc_pair_t p;
		int         kind, span, cx, cy;
		kind = $urandom_range(99);
		span = 1 << $urandom_range(1, 21);
		cx   = int'($urandom_range(0, 1 << 23)) - (1 << 22);
		cy   = int'($urandom_range(0, 1 << 23)) - (1 << 22);
		p.a_x  = 24'(cx);
		p.a_y  = 24'(cy);
		p.a_r  = 23'($urandom_range(0, span));
		p.b_r  = 23'($urandom_range(0, span));
		p.a_vx = rand_vel(span);
		p.a_vy = rand_vel(span);
		p.b_vx = rand_vel(span);
		p.b_vy = rand_vel(span);
		if (kind < 60) begin
			p.b_x = 24'(cx + int'($urandom_range(0, 2 * span)) - span);
			p.b_y = 24'(cy + int'($urandom_range(0, 2 * span)) - span);
		end else if (kind < 85) begin
			p = disc_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom});
		end else if (kind < 93) begin
			p.b_x = p.a_x;
			p.b_y = p.a_y;
		end else begin
			// touching exactly along x: d.d == (rA+rB)^2
			p.b_x = 24'(cx + int'(p.a_r) + int'(p.b_r));
			p.b_y = p.a_y;
		end
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------

	task automatic flag(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// four-state compare, so an unknown output bit is a mismatch too
	task automatic check_field(input string name, input logic signed [63:0] got,
			input logic signed [63:0] want);
		if (got !== want) begin
			flag($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: check each accepted transaction against the oldest
	// expectation, then pick this cycle's ready for the next edge.
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		collision_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				flag("result with nothing expected");
			end else begin
				want = due_results.pop_front();
				check_field("hit", hit, want.hit);
				check_field("new_a_vx", new_a_vx, want.new_a_vx);
				check_field("new_a_vy", new_a_vy, want.new_a_vy);
				check_field("new_b_vx", new_b_vx, want.new_b_vx);
				check_field("new_b_vy", new_b_vy, want.new_b_vy);
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one pair; valid stays high with a stable payload until the
	// transaction is taken. in_ready read right after the edge is the value
	// the block saw at that edge.
	task automatic offer_pair(input disc_pair_t p, input bit typed, input collision_t want);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_x  <= p.a_x;
		a_y  <= p.a_y;
		a_vx <= p.a_vx;
		a_vy <= p.a_vy;
		a_r  <= p.a_r;
		b_x  <= p.b_x;
		b_y  <= p.b_y;
		b_vx <= p.b_vx;
		b_vy <= p.b_vy;
		b_r  <= p.b_r;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		due_results.push_back(typed ? want : predict_exchange(p));
	endtask

	// Hold the sender off until every outstanding result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		// Hand-checked rows: contact edge cases, pass-through and saturation.
		// Zero everything: coincident centres, zero radii still count as contact.
		dir_rows.push_back({mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1'b1, 0, 0, 0, 0)});
		// Coincident centres with extreme velocities: no move, pass-through.
		dir_rows.push_back({mk_pair(100, -200, 8388607, -8388608, 0,
			100, -200, -8388608, 8388607, 0), 1'b1,
			mk_res(1'b1, 8388607, -8388608, -8388608, 8388607)});
		// Head-on along x, exactly touching: x velocities swap.
		dir_rows.push_back({mk_pair(0, 0, 1000, -50, 128, 256, 0, -300, 70, 128), 1'b1,
			mk_res(1'b1, -300, -50, 1000, 70)});
		// One LSB further apart: no contact.
		dir_rows.push_back({mk_pair(0, 0, 1000, -50, 128, 257, 0, -300, 70, 128), 1'b1,
			mk_res(1'b0, 1000, -50, -300, 70)});
		// Opposite coordinate corners, largest radii: still apart.
		dir_rows.push_back({mk_pair(-8388608, -8388608, 5, -5, 8388607,
			8388607, 8388607, 7, -7, 8388607), 1'b1,
			mk_res(1'b0, 5, -5, 7, -7)});
		// Full x span, largest radii: apart by one LSB of the radius sum.
		dir_rows.push_back({mk_pair(-8388608, 0, 1, 2, 8388607,
			8388607, 0, 3, 4, 8388607), 1'b1,
			mk_res(1'b0, 1, 2, 3, 4)});
		// Diagonal contact, largest relative speed: A's y saturates low.
		dir_rows.push_back({mk_pair(0, 0, 8388607, -8388608, 1,
			1, 1, -8388608, -8388608, 1), 1'b1,
			mk_res(1'b1, 0, -8388608, -1, -1)});
		// Mirror case: A's y saturates high.
		dir_rows.push_back({mk_pair(0, 0, -8388608, 8388607, 1,
			1, 1, 8388607, 8388607, 1), 1'b1,
			mk_res(1'b1, -1, 8388607, 0, 0)});
		// Predictor rows.
		dir_rows.push_back({mk_pair(8388607, 8388607, -8388608, 8388607, 8388607,
			-8388608, -8388608, 8388607, -8388608, 8388607), 1'b0, NO_RES});
		dir_rows.push_back({mk_pair(-4000000, 3000000, 8388607, 8388607, 8388607,
			4000000, -3000000, -8388608, -8388608, 8388607), 1'b0, NO_RES});
		dir_rows.push_back({mk_pair(0, 0, 300, -700, 500, 300, 400, -100, 250, 100),
			1'b0, NO_RES});
		dir_rows.push_back({mk_pair(0, 0, -1, 1, 8388607, 5000000, -6000000, 1, -1, 0),
			1'b0, NO_RES});
		dir_rows.push_back({mk_pair(-1234, 5678, -8388608, -8388608, 3000,
			-3456, 3210, 8388607, 8388607, 2000), 1'b0, NO_RES});
		dir_rows.push_back({mk_pair(7, -3, 12345, -54321, 1, 6, -2, -777, 888, 1),
			1'b0, NO_RES});
		dir_rows.push_back({mk_pair(-8388608, 8388607, 3, 3, 'h555555,
			-8388608 + 'h2AAAAA, 8388607 - 'h155555, -3, -3, 'h2AAAAA), 1'b0, NO_RES});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at full rate.
		foreach (dir_rows[k]) begin
			offer_pair(dir_rows[k].pair, dir_rows[k].typed, dir_rows[k].want);
		end
		drain();

		// Random part: free-running, sender idle, receiver stalling, both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			for (int n = 0; n < RAND_ITEMS; n++) begin
				offer_pair(rand_pair(), 1'b0, NO_RES);
			end
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
